// ===== rtl/acc_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the consensus block.
package acc_pkg;

   localparam int ALPHABET   = 26;
   localparam int MCOLS      = ALPHABET + 1;
   localparam int MAT_DEPTH  = ALPHABET * MCOLS;
   localparam int MAT_AW     = $clog2(MAT_DEPTH);
   localparam int IDX_W      = 5;
   localparam int SCORE_W    = 8;
   localparam int WEIGHT_W   = 16;
   localparam int CUTOFF_W   = 16;
   localparam int CODE_W     = 5;
   localparam int LSUM_W     = 36;
   localparam int WSUM_W     = 26;
   localparam int PROD_W     = WEIGHT_W + SCORE_W + 1;
   localparam int TOT_W      = LSUM_W + 5;
   localparam int MUL_W      = 112;
   localparam int MB_W       = TOT_W;
   localparam int LHS_SHIFT  = 16;

   localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 16'd512;
   localparam logic [CODE_W-1:0]   GAP_CODE   = 5'd26;
   localparam logic [CODE_W-1:0]   X_CODE     = 5'd27;
   localparam logic [IDX_W-1:0]    LAST_IDX   = 5'd25;
   localparam logic [MB_W-1:0]     MULT_ALPHA = MB_W'(ALPHABET);
   localparam logic [MB_W-1:0]     MULT_ALPHA2 = MB_W'(ALPHABET * ALPHABET);

   typedef enum logic [2:0] {
      OP_SQ, OP_M26, OP_TOT, OP_RHS, OP_BSQ, OP_B676
   } op_type;

   typedef enum logic [1:0] {
      RES_GAP, RES_BEST, RES_X
   } res_type;

   typedef struct packed {
      logic             accept;
      logic             mac_issue;
      logic [IDX_W-1:0] idx;
      logic             mul_load;
      op_type           op;
      logic             first;
      logic             mul_run;
      logic             sub_v;
      logic             emit;
      res_type          res;
   } dp_cmd_type;

   typedef struct packed {
      logic func;
      logic column_end;
      logic gap_wins;
      logic mul_zero;
      logic v_zero;
      logic best_pos;
      logic lhs_gt;
   } dp_sts_type;

endpackage

// ===== rtl/acc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module acc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 702
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/acc_ctrl.sv =====
// Controller state machine: handshakes, residue sweep and column-end statistics sequence.
module acc_ctrl import acc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_DISP, ST_MAC, ST_DRAIN, ST_GAPCHK, ST_LOAD, ST_RUN,
      ST_DECIDE, ST_CMP, ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   op_type           op_ff, op_in;
   res_type          res_ff, res_in;
   logic             full_ff, full_in;
   logic             can_emit;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = full_ff;
   assign can_emit  = !full_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      res_in   = res_ff;
      full_in  = (full_ff && !rsp_stall) ? 1'b0 : full_ff;
      cmd           = '0;
      cmd.idx       = cnt_ff;
      cmd.op        = op_ff;
      cmd.res       = res_ff;
      cmd.first     = (cnt_ff == '0);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISP;
            end
         end
         ST_DISP: begin
            cnt_in   = '0;
            state_in = sts.func ? ST_MAC : ST_IDLE;
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (cnt_ff != '0) begin
               state_in = sts.column_end ? ST_GAPCHK : ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_GAPCHK: begin
            if (sts.gap_wins) begin
               res_in   = RES_GAP;
               state_in = ST_EMIT;
            end else begin
               op_in    = OP_SQ;
               cnt_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_RUN;
         end
         ST_RUN: begin
            if (!sts.mul_zero) begin
               cmd.mul_run = 1'b1;
            end else begin
               state_in = ST_LOAD;
               unique case (op_ff)
                  OP_SQ: begin
                     if (cnt_ff == LAST_IDX) begin
                        op_in = OP_M26;
                     end else begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  OP_M26:  op_in = OP_TOT;
                  OP_TOT: begin
                     cmd.sub_v = 1'b1;
                     state_in  = ST_DECIDE;
                  end
                  OP_RHS:  op_in = OP_BSQ;
                  OP_BSQ:  op_in = OP_B676;
                  OP_B676: state_in = ST_CMP;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DECIDE: begin
            priority if (sts.v_zero) begin
               res_in   = RES_BEST;
               state_in = ST_EMIT;
            end else if (!sts.best_pos) begin
               res_in   = RES_X;
               state_in = ST_EMIT;
            end else begin
               op_in    = OP_RHS;
               state_in = ST_LOAD;
            end
         end
         ST_CMP: begin
            res_in   = sts.lhs_gt ? RES_BEST : RES_X;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (can_emit) begin
               cmd.emit = 1'b1;
               full_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         op_ff    <= OP_SQ;
         res_ff   <= RES_X;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         op_ff    <= op_in;
         res_ff   <= res_in;
         full_ff  <= full_in;
      end
   end
endmodule

// ===== rtl/acc_dp.sv =====
// Datapath: score matrix, letter and weight sums, serial multiplier and result register.
module acc_dp import acc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_sts_type                 sts,
   input  logic                       req_func,
   input  logic [IDX_W-1:0]           req_row,
   input  logic [IDX_W-1:0]           req_col,
   input  logic signed [SCORE_W-1:0]  req_score,
   input  logic [IDX_W-1:0]           req_residue,
   input  logic [WEIGHT_W-1:0]        req_weight,
   input  logic                       req_column_end,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CUTOFF_W-1:0]        csr_data,
   output logic [CODE_W-1:0]          rsp_consensus_code
);
   logic                      func_ff, colend_ff;
   logic [IDX_W-1:0]          res_ff;
   logic [WEIGHT_W-1:0]       weight_ff;
   logic [CUTOFF_W-1:0]       cutoff_ff;
   logic [WSUM_W-1:0]         gap_ff, rsd_ff;
   logic signed [LSUM_W-1:0]  sums_ff [ALPHABET];
   logic                      v1_ff, v2_ff;
   logic [IDX_W-1:0]          i1_ff, i2_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [MUL_W-1:0]          a_ff, p_ff, v_ff, rhs_ff;
   logic [MB_W-1:0]           b_ff;
   logic signed [TOT_W-1:0]   total_ff;
   logic signed [LSUM_W-1:0]  best_ff;
   logic [IDX_W-1:0]          bidx_ff;
   logic [CODE_W-1:0]         code_ff;

   logic                      mat_we;
   logic [MAT_AW-1:0]         mat_waddr, mat_raddr;
   logic [SCORE_W-1:0]        mat_rdata;
   logic [IDX_W-1:0]          res_eff;
   logic                      is_gap;
   logic [WSUM_W:0]           wsum_t;
   logic signed [LSUM_W:0]    lsum_t;
   logic signed [LSUM_W-1:0]  cur_s;
   logic [LSUM_W-1:0]         cur_mag;
   logic [TOT_W-1:0]          tot_mag;
   logic [2*CUTOFF_W-1:0]     cut_sq;
   logic signed [TOT_W-1:0]   total_new;

   assign mat_we    = cmd.accept && !req_func && (req_row < IDX_W'(ALPHABET))
                      && (req_col < IDX_W'(MCOLS));
   assign mat_waddr = MAT_AW'(req_row) * MAT_AW'(MCOLS) + MAT_AW'(req_col);
   assign mat_raddr = MAT_AW'(cmd.idx) * MAT_AW'(MCOLS) + MAT_AW'(res_ff);

   acc_ram #(.WIDTH(SCORE_W), .DEPTH(MAT_DEPTH)) u_matrix (
      .clock (clock),
      .we    (mat_we),
      .waddr (mat_waddr),
      .wdata (req_score),
      .raddr (mat_raddr),
      .rdata (mat_rdata)
   );

   assign is_gap  = (req_residue >= IDX_W'(ALPHABET));
   assign res_eff = is_gap ? IDX_W'(ALPHABET) : req_residue;
   assign wsum_t  = is_gap ? ({1'b0, gap_ff} + (WSUM_W+1)'(req_weight))
                           : ({1'b0, rsd_ff} + (WSUM_W+1)'(req_weight));
   assign lsum_t  = (LSUM_W+1)'(sums_ff[i2_ff]) + (LSUM_W+1)'(prod_ff);

   assign cur_s     = sums_ff[cmd.idx];
   assign cur_mag   = cur_s[LSUM_W-1] ? LSUM_W'(-cur_s) : LSUM_W'(cur_s);
   assign tot_mag   = total_ff[TOT_W-1] ? TOT_W'(-total_ff) : TOT_W'(total_ff);
   assign cut_sq    = {{CUTOFF_W{1'b0}}, cutoff_ff} * {{CUTOFF_W{1'b0}}, cutoff_ff};
   assign total_new = total_ff + TOT_W'(cur_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         func_ff   <= 1'b0;
         colend_ff <= 1'b0;
         cutoff_ff <= CUTOFF_RST;
         gap_ff    <= '0;
         rsd_ff    <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         for (int i = 0; i < ALPHABET; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            cutoff_ff <= csr_data;
         end
         if (cmd.accept) begin
            func_ff   <= req_func;
            colend_ff <= req_column_end;
            if (req_func) begin
               if (is_gap) begin
                  gap_ff <= wsum_t[WSUM_W] ? '1 : wsum_t[WSUM_W-1:0];
               end else begin
                  rsd_ff <= wsum_t[WSUM_W] ? '1 : wsum_t[WSUM_W-1:0];
               end
            end
         end
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
         if (v2_ff) begin
            if (lsum_t[LSUM_W] != lsum_t[LSUM_W-1]) begin
               sums_ff[i2_ff] <= lsum_t[LSUM_W] ? {1'b1, {(LSUM_W-1){1'b0}}}
                                                : {1'b0, {(LSUM_W-1){1'b1}}};
            end else begin
               sums_ff[i2_ff] <= lsum_t[LSUM_W-1:0];
            end
         end
         if (cmd.emit) begin
            gap_ff <= '0;
            rsd_ff <= '0;
            for (int i = 0; i < ALPHABET; i++) begin
               sums_ff[i] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_ff    <= res_eff;
         weight_ff <= req_weight;
      end
      i1_ff   <= cmd.idx;
      i2_ff   <= i1_ff;
      prod_ff <= $signed({1'b0, weight_ff}) * $signed(mat_rdata);
      if (cmd.mul_load) begin
         unique case (cmd.op)
            OP_SQ: begin
               a_ff <= MUL_W'(cur_mag);
               b_ff <= MB_W'(cur_mag);
               if (cmd.first) begin
                  p_ff     <= '0;
                  total_ff <= TOT_W'(cur_s);
                  best_ff  <= cur_s;
                  bidx_ff  <= cmd.idx;
               end else begin
                  total_ff <= total_new;
                  if (cur_s > best_ff) begin
                     best_ff <= cur_s;
                     bidx_ff <= cmd.idx;
                  end
               end
            end
            OP_M26: begin
               a_ff <= p_ff;
               b_ff <= MULT_ALPHA;
               p_ff <= '0;
            end
            OP_TOT: begin
               v_ff <= p_ff;
               a_ff <= MUL_W'(tot_mag);
               b_ff <= tot_mag;
               p_ff <= '0;
            end
            OP_RHS: begin
               a_ff <= v_ff;
               b_ff <= MB_W'(cut_sq);
               p_ff <= '0;
            end
            OP_BSQ: begin
               rhs_ff <= p_ff;
               a_ff   <= MUL_W'(best_ff);
               b_ff   <= MB_W'(best_ff);
               p_ff   <= '0;
            end
            OP_B676: begin
               a_ff <= p_ff;
               b_ff <= MULT_ALPHA2;
               p_ff <= '0;
            end
            default: p_ff <= '0;
         endcase
      end else if (cmd.mul_run) begin
         if (b_ff[0]) begin
            p_ff <= p_ff + a_ff;
         end
         a_ff <= a_ff << 1;
         b_ff <= b_ff >> 1;
      end
      if (cmd.sub_v) begin
         v_ff <= v_ff - p_ff;
      end
      if (cmd.emit) begin
         unique case (cmd.res)
            RES_GAP:  code_ff <= GAP_CODE;
            RES_BEST: code_ff <= CODE_W'(bidx_ff);
            default:  code_ff <= X_CODE;
         endcase
      end
   end

   assign sts.func       = func_ff;
   assign sts.column_end = colend_ff;
   assign sts.gap_wins   = (gap_ff > rsd_ff);
   assign sts.mul_zero   = (b_ff == '0);
   assign sts.v_zero     = (v_ff == '0);
   assign sts.best_pos   = !best_ff[LSUM_W-1] && (best_ff != '0);
   assign sts.lhs_gt     = ({p_ff[MUL_W-LHS_SHIFT-1:0], {LHS_SHIFT{1'b0}}} > rhs_ff);

   assign rsp_consensus_code = code_ff;
endmodule

// ===== rtl/alignment_column_consensus.sv =====
// Top level of the weighted alignment column consensus block.
//
//   channel  direction  handshake            carries
//   req_     in         req_valid/req_stall  matrix entry or weighted residue
//   rsp_     out        rsp_valid/rsp_stall  consensus code per column
//   csr_     in         csr_valid/csr_ready  cutoff, unsigned Q8.8
//
// A matrix entry is written into the score memory when accepted, if in range; a residue makes
// 26 reads of the matrix memory port feeding one multiply-accumulate, then drains the pipeline.
// A column end adds the statistics pass on the bit-serial multiplier: a sum of squares
// over the letter sums, then the remaining products of the cutoff comparison.
// Reset is synchronous; it clears the sums and sets the cutoff to 2.0.
// A held result does not stop the next item; only a second result waits.
module alignment_column_consensus import acc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_func,
   input  logic [IDX_W-1:0]          req_row,
   input  logic [IDX_W-1:0]          req_col,
   input  logic signed [SCORE_W-1:0] req_score,
   input  logic [IDX_W-1:0]          req_residue,
   input  logic [WEIGHT_W-1:0]       req_weight,
   input  logic                      req_column_end,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CODE_W-1:0]         rsp_consensus_code,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CUTOFF_W-1:0]       csr_data
);
   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   acc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   acc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_func           (req_func),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_score          (req_score),
      .req_residue        (req_residue),
      .req_weight         (req_weight),
      .req_column_end     (req_column_end),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .rsp_consensus_code (rsp_consensus_code)
   );
endmodule

// ===== rtl/acc_chk.sv =====
// Port-level checker for the consensus block, bound to the top level.
module acc_chk import acc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CODE_W-1:0] rsp_consensus_code
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_consensus_code))
      else $error("result beat dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken on two consecutive cycles");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_consensus_code <= X_CODE))
      else $error("consensus code out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");
endmodule

bind alignment_column_consensus acc_chk u_acc_chk (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_consensus_code (rsp_consensus_code)
);

// ===== bench/alignment_column_consensus_tb.sv =====
// Self-checking bench for the column consensus block: matrix loads, weighted columns, cutoffs.
`timescale 1ns / 1ps
module alignment_column_consensus_tb;
   import acc_pkg::*;

   typedef struct {
      logic                      func;
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
      logic signed [SCORE_W-1:0] score;
      logic [IDX_W-1:0]          residue;
      logic [WEIGHT_W-1:0]       weight;
      logic                      column_end;
   } beat_type;

   localparam longint LSUM_HI = 64'sh7_FFFF_FFFF;
   localparam longint LSUM_LO = -64'sh8_0000_0000;
   localparam int unsigned WSUM_HI = 32'h3FF_FFFF;

   logic clock, reset;
   logic req_valid, req_stall, req_func, req_column_end;
   logic [IDX_W-1:0] req_row, req_col, req_residue;
   logic signed [SCORE_W-1:0] req_score;
   logic [WEIGHT_W-1:0] req_weight;
   logic rsp_valid, rsp_stall;
   logic [CODE_W-1:0] rsp_consensus_code;
   logic csr_valid, csr_ready;
   logic [CUTOFF_W-1:0] csr_data;

   beat_type pending_beats[$];
   logic [CODE_W-1:0] code_fifo[$];
   int send_idle, recv_idle, hold_asked, hold_done, hold_cnt, errors, columns_seen;
   logic req_fire;

   int score_tab[ALPHABET][MCOLS];
   longint letter_acc[ALPHABET];
   int unsigned gap_acc, res_acc;
   logic [CUTOFF_W-1:0] cutoff_q;

   alignment_column_consensus u_top (.*);

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   function automatic logic [127:0] square_mag(longint v);
      logic [127:0] m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      return m * m;
   endfunction

   function automatic logic [CODE_W-1:0] column_code();
      int b;
      longint total;
      logic [127:0] sq, var26, lhs, rhs;
      b = 0;
      total = 0;
      sq = '0;
      if (gap_acc > res_acc) return GAP_CODE;
      for (int i = 0; i < ALPHABET; i++) begin
         if (letter_acc[i] > letter_acc[b]) b = i;
         total += letter_acc[i];
         sq += square_mag(letter_acc[i]);
      end
      var26 = sq * ALPHABET - square_mag(total);
      if (var26 == 0) return CODE_W'(b);
      if (letter_acc[b] <= 0) return X_CODE;
      lhs = square_mag(letter_acc[b]) * 676 * 65536;
      rhs = var26 * (128'(cutoff_q) * 128'(cutoff_q));
      return (lhs > rhs) ? CODE_W'(b) : X_CODE;
   endfunction

   task automatic clear_sums();
      foreach (letter_acc[i]) letter_acc[i] = 0;
      gap_acc = 0;
      res_acc = 0;
   endtask

   task automatic accumulate_beat(beat_type b);
      int r;
      longint s;
      if (!b.func) begin
         if (b.row < ALPHABET && b.col < MCOLS) score_tab[b.row][b.col] = int'(b.score);
         return;
      end
      r = b.residue;
      if (r >= ALPHABET) begin
         r = ALPHABET;
         gap_acc = (gap_acc + b.weight > WSUM_HI) ? WSUM_HI : gap_acc + b.weight;
      end else begin
         res_acc = (res_acc + b.weight > WSUM_HI) ? WSUM_HI : res_acc + b.weight;
      end
      for (int i = 0; i < ALPHABET; i++) begin
         s = letter_acc[i] + longint'(b.weight) * score_tab[i][r];
         if (s > LSUM_HI) s = LSUM_HI;
         if (s < LSUM_LO) s = LSUM_LO;
         letter_acc[i] = s;
      end
      if (b.column_end) begin
         code_fifo.push_back(column_code());
         clear_sums();
      end
   endtask

   // accepted request beats feed the predictor
   always @(posedge clock) begin
      beat_type b;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         b.func = req_func; b.row = req_row; b.col = req_col; b.score = req_score;
         b.residue = req_residue; b.weight = req_weight; b.column_end = req_column_end;
         accumulate_beat(b);
      end
   end

   always @(negedge clock) begin
      beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
            b = pending_beats.pop_front();
            req_valid <= 1'b1;
            req_func <= b.func; req_row <= b.row; req_col <= b.col; req_score <= b.score;
            req_residue <= b.residue; req_weight <= b.weight;
            req_column_end <= b.column_end;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure, with a long hold when asked
   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt <= hold_cnt - 1;
      end else if (hold_done < hold_asked) begin
         rsp_stall <= 1'b1;
         hold_cnt <= 3000;
         hold_done <= hold_done + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle);
      end
   end

   always @(posedge clock) begin
      logic [CODE_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         columns_seen <= columns_seen + 1;
         if (code_fifo.size() == 0) begin
            $display("%0t: unexpected consensus beat, expected none, actual %0d",
                     $time, rsp_consensus_code);
            errors++;
         end else begin
            want = code_fifo.pop_front();
            if (rsp_consensus_code !== want) begin
               $display("%0t: consensus_code mismatch, expected %0d, actual %0d",
                        $time, want, rsp_consensus_code);
               errors++;
            end
         end
      end
   end

   task automatic set_mode(int phase);
      case (phase % 3)
         0: begin send_idle = 37; recv_idle = 81; end
         1: begin send_idle = 81; recv_idle = 37; end
         default: begin send_idle = 0; recv_idle = 0; end
      endcase
   endtask

   task automatic push_load(int row, int col, int score, logic cend);
      beat_type b;
      b.func = 1'b0; b.row = IDX_W'(row); b.col = IDX_W'(col);
      b.score = SCORE_W'(score);
      b.residue = IDX_W'($urandom); b.weight = WEIGHT_W'($urandom); b.column_end = cend;
      pending_beats.push_back(b);
   endtask

   task automatic push_residue(int res, int w, logic cend);
      beat_type b;
      b.func = 1'b1; b.row = IDX_W'($urandom); b.col = IDX_W'($urandom);
      b.score = SCORE_W'($urandom);
      b.residue = IDX_W'(res); b.weight = WEIGHT_W'(w); b.column_end = cend;
      pending_beats.push_back(b);
   endtask

   function automatic int pick_weight();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return 0;
      if (p == 1) return 16'hFFFF;
      return $urandom_range(0, 65535);
   endfunction

   task automatic push_column();
      int len, dom, r;
      len = $urandom_range(1, 6);
      dom = $urandom_range(0, 25);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 10) r = $urandom_range(26, 31);
         else if ($urandom_range(0, 99) < 60) r = dom;
         else r = $urandom_range(0, 25);
         push_residue(r, pick_weight(), i == len - 1);
      end
   endtask

   task automatic drain(int cycles);
      while (pending_beats.size() > 0 || req_valid || code_fifo.size() > 0) @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_cutoff(logic [CUTOFF_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      cutoff_q = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [CUTOFF_W-1:0] cutoffs[6];
      int loads, residues;
      cutoffs = '{16'd512, 16'd0, 16'hFFFF, 16'd256, 16'd0, 16'd1};
      cutoffs[4] = CUTOFF_W'($urandom);
      req_valid = 0; req_func = 0; req_row = 0; req_col = 0; req_score = 0;
      req_residue = 0; req_weight = 0; req_column_end = 0; rsp_stall = 0;
      csr_valid = 0; csr_data = 0; req_fire = 0;
      hold_asked = 0; hold_done = 0; hold_cnt = 0; errors = 0; columns_seen = 0;
      loads = 0; residues = 0;
      cutoff_q = CUTOFF_RST;
      clear_sums();
      set_mode(0);
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // full matrix: strong diagonal, equal scores for residue A, extremes present
      for (int r = 0; r < ALPHABET; r++)
         for (int c = 0; c < MCOLS; c++) begin
            if (c == 0) push_load(r, c, 5, 1'b0);
            else if (r == c) push_load(r, c, $urandom_range(60, 127), 1'b0);
            else push_load(r, c, int'($urandom_range(0, 40)) - 20, 1'b0);
         end
      push_load(1, 2, 127, 1'b0);
      push_load(25, 2, -128, 1'b1);
      push_load(31, 3, 99, 1'b0);
      push_load(4, 31, 99, 1'b0);
      push_load(26, 27, -1, 1'b1);
      push_residue(26, 16'hFFFF, 1'b1);
      push_residue(31, 100, 1'b0);
      push_residue(3, 50, 1'b1);
      push_residue(0, 0, 1'b1);
      push_residue(0, 16'hFFFF, 1'b0);
      push_residue(0, 1234, 1'b1);
      push_residue(2, 16'hFFFF, 1'b0);
      push_residue(25, 16'hFFFF, 1'b1);
      push_residue(27, 0, 1'b1);
      push_residue(7, 16'hFFFF, 1'b0);
      push_residue(8, 16'hFFFF, 1'b0);
      push_residue(30, 16'hFFFF, 1'b1);
      drain(64);

      for (int ph = 0; ph < 6; ph++) begin
         set_mode(ph);
         if (ph > 0) write_cutoff(cutoffs[ph]);
         if (ph == 1) hold_asked = hold_asked + 1;
         while (pending_beats.size() < 22) begin
            if ($urandom_range(0, 99) < 8) begin
               if ($urandom_range(0, 3) == 0)
                  push_load($urandom_range(0, 31), $urandom_range(0, 31), $urandom,
                            1'($urandom));
               else
                  push_load($urandom_range(0, 25), $urandom_range(0, 26), $urandom,
                            1'($urandom));
               loads++;
            end else begin
               push_column();
               residues++;
            end
         end
         drain(64);
      end

      drain(2000);
      $display("Covered %0d random columns and %0d matrix rewrites over six cutoff settings,",
               residues, loads);
      $display("with %0d consensus beats checked under varied stall and idle patterns.",
               columns_seen);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
